[rtl/fsps_pkg.sv]
package fsps_pkg;

    localparam int CmdW  = 3;
    localparam int PidW  = 16;
    localparam int GrpW  = 8;
    localparam int CpuW  = 16;
    localparam int PrioW = 22;
    localparam int StW   = 2;

    localparam logic [CmdW-1:0] CMD_ADD_READY = 3'd0;
    localparam logic [CmdW-1:0] CMD_ADD_SUSP  = 3'd1;
    localparam logic [CmdW-1:0] CMD_RESUME    = 3'd2;
    localparam logic [CmdW-1:0] CMD_REMOVE    = 3'd3;
    localparam logic [CmdW-1:0] CMD_SET_GROUP = 3'd4;
    localparam logic [CmdW-1:0] CMD_SCHEDULE  = 3'd5;

    localparam logic [StW-1:0] ST_OK   = 2'd0;
    localparam logic [StW-1:0] ST_FULL = 2'd1;
    localparam logic [StW-1:0] ST_MISS = 2'd2;

    // input tdata: cmd, proc_id, group_id, cpu_usage, group_usage, group_count
    localparam int InW  = CmdW + PidW + GrpW + CpuW + CpuW + GrpW; // 67
    localparam int InTW = 72;
    // output tdata: status, out_pid, out_group, out_priority
    localparam int OutW  = StW + PidW + GrpW + PrioW; // 48
    localparam int OutTW = 48;

    typedef struct packed {
        logic             rdy;
        logic [PidW-1:0]  pid;
        logic [GrpW-1:0]  grp;
        logic [CpuW-1:0]  cpu;
        logic [CpuW-1:0]  gcpu;
        logic [PrioW-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [StW-1:0]   status;
        logic [PidW-1:0]  pid;
        logic [GrpW-1:0]  grp;
        logic [PrioW-1:0] prio;
    } t_result;

endpackage

[rtl/fsps_prio_unit.sv]
// Shared per-entry arithmetic: halves both counts and computes the priority.
module fsps_prio_unit
    import fsps_pkg::*;
(
    input  logic [CpuW-1:0]  i_cpu,
    input  logic [CpuW-1:0]  i_gcpu,
    input  logic [GrpW-1:0]  i_groups,
    input  logic [GrpW-1:0]  i_base,
    output logic [CpuW-1:0]  o_cpu,
    output logic [CpuW-1:0]  o_gcpu,
    output logic [PrioW-1:0] o_prio
);
    logic [CpuW+GrpW-2:0] w_prod;

    assign o_cpu  = {1'b0, i_cpu[CpuW-1:1]};
    assign o_gcpu = {1'b0, i_gcpu[CpuW-1:1]};
    assign w_prod = o_gcpu[CpuW-2:0] * i_groups;
    assign o_prio = PrioW'(i_base) + PrioW'(o_cpu[CpuW-1:1])
                  + PrioW'(w_prod[CpuW+GrpW-2:2]);
endmodule

[rtl/fair_share_process_scheduler_core.sv]
// Channel | Dir | Handshake           | Payload
// s_axis  | in  | tvalid/tready       | tdata: command fields (72b)
// m_axis  | out | tvalid/tready       | tdata: result fields (48b)
// cfg     | in  | i_cfg_we            | base priority (8b)
// Add and unused commands go from the scan state straight to the output state;
// resume, remove, set-group and schedule walk the table one slot per cycle, with
// schedule using the shared priority unit, and remove/resume/schedule compact the
// table in a second walk. Reset clears the count, control and base priority only.
// Output stalls hold the result register; no new command until it is taken.
module fair_share_process_scheduler_core
    import fsps_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] cmd, [18:3] proc_id, [26:19] group_id, [42:27] cpu_usage,
    // [58:43] group_usage, [66:59] group_count, [71:67] zero
    input  logic [InTW-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [1:0] status, [17:2] out_pid, [25:18] out_group, [47:26] out_priority
    output logic [OutTW-1:0] m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [GrpW-1:0]  i_cfg_wdata
);
    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    t_entry r_tab [TABLE_DEPTH];
    logic [CntW-1:0] r_count;
    logic [2:0]      r_state;
    logic [IdxW-1:0] r_idx;
    logic [CntW-1:0] r_hit;
    logic            r_found;
    logic [PrioW-1:0] r_best;
    logic [IdxW-1:0] r_bidx;
    t_entry          r_save;
    logic [GrpW-1:0] r_base;
    logic [CmdW-1:0] r_cmd;
    logic [PidW-1:0] r_pid;
    logic [GrpW-1:0] r_grp;
    logic [CpuW-1:0] r_cpu;
    logic [CpuW-1:0] r_gcpu;
    logic [GrpW-1:0] r_groups;
    t_result         r_res;
    logic            r_ovalid;

    t_entry          w_cur;
    logic [CpuW-1:0] w_hc, w_hg;
    logic [PrioW-1:0] w_prio;
    logic            w_last;

    assign w_cur  = r_tab[r_idx];
    assign w_last = (CntW'(r_idx) + 1'b1 >= r_count);

    fsps_prio_unit u_prio (
        .i_cpu(w_cur.cpu), .i_gcpu(w_cur.gcpu), .i_groups(r_groups),
        .i_base(r_base), .o_cpu(w_hc), .o_gcpu(w_hg), .o_prio(w_prio)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_res.prio, r_res.grp, r_res.pid, r_res.status};

    // base priority register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base <= '0;
        else if (i_cfg_we) r_base <= i_cfg_wdata;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd    <= s_axis_tdata[2:0];
                        r_pid    <= s_axis_tdata[18:3];
                        r_grp    <= s_axis_tdata[26:19];
                        r_cpu    <= s_axis_tdata[42:27];
                        r_gcpu   <= s_axis_tdata[58:43];
                        r_groups <= s_axis_tdata[66:59];
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_res    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    priority if (r_cmd == CMD_ADD_READY || r_cmd == CMD_ADD_SUSP) begin
                        if (r_count >= CntW'(TABLE_DEPTH)) r_res.status <= ST_FULL;
                        else begin
                            r_tab[r_count[IdxW-1:0]] <= '{rdy: (r_cmd == CMD_ADD_READY),
                                pid: r_pid, grp: r_grp, cpu: r_cpu, gcpu: r_gcpu,
                                prio: '0};
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (r_cmd == CMD_RESUME || r_cmd == CMD_REMOVE) begin
                        if (r_count == '0) begin
                            r_res.status <= ST_MISS;
                            r_state <= S_OUT;
                        end else if (w_cur.pid == r_pid &&
                                     (r_cmd == CMD_REMOVE || !w_cur.rdy)) begin
                            r_save <= w_cur;
                            if (r_cmd == CMD_REMOVE) begin
                                r_res.pid <= w_cur.pid;
                                r_res.grp <= w_cur.grp;
                            end
                            r_state <= S_MOVE;
                        end else if (w_last) begin
                            r_res.status <= ST_MISS;
                            r_state <= S_OUT;
                        end else r_idx <= r_idx + 1'b1;
                    end else if (r_cmd == CMD_SET_GROUP) begin
                        if (r_count == '0) r_state <= S_OUT;
                        else begin
                            if (w_cur.grp == r_grp) r_tab[r_idx].gcpu <= r_gcpu;
                            if (w_last) r_state <= S_OUT;
                            else r_idx <= r_idx + 1'b1;
                        end
                    end else if (r_cmd == CMD_SCHEDULE) begin
                        if (r_count == '0) begin
                            r_res.status <= ST_MISS;
                            r_state <= S_OUT;
                        end else begin
                            r_tab[r_idx].cpu  <= w_hc;
                            r_tab[r_idx].gcpu <= w_hg;
                            r_tab[r_idx].prio <= w_prio;
                            if (w_cur.rdy && (!r_found || w_prio < r_best)) begin
                                r_found <= 1'b1;
                                r_best  <= w_prio;
                                r_bidx  <= r_idx;
                            end
                            if (w_last) begin
                                if (w_cur.rdy && (!r_found || w_prio < r_best)) begin
                                    r_res <= '{status: ST_OK, pid: w_cur.pid,
                                               grp: w_cur.grp, prio: w_prio};
                                    r_state <= S_MOVE;
                                end else if (r_found) begin
                                    r_res <= '{status: ST_OK, pid: r_tab[r_bidx].pid,
                                               grp: r_tab[r_bidx].grp, prio: r_best};
                                    r_idx <= r_bidx;
                                    r_state <= S_MOVE;
                                end else begin
                                    r_res.status <= ST_MISS;
                                    r_state <= S_OUT;
                                end
                            end else r_idx <= r_idx + 1'b1;
                        end
                    end else r_state <= S_OUT;
                end
                S_MOVE: begin
                    // shift later entries up one slot
                    if (w_last) begin
                        if (r_cmd == CMD_RESUME) r_state <= S_TAIL;
                        else begin
                            r_count <= r_count - 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_tab[r_idx] <= r_tab[r_idx + 1'b1];
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TAIL: begin
                    r_tab[r_idx] <= '{rdy: 1'b1, pid: r_save.pid, grp: r_save.grp,
                        cpu: r_save.cpu, gcpu: r_save.gcpu, prio: r_save.prio};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/fsps_checker.sv]
module fsps_checker
    import fsps_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OutTW-1:0] m_axis_tdata
);
    // no new command while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready during result");
    // no result right after an accept
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early result");
    // status code in range
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

bind fair_share_process_scheduler_core fsps_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
